/* rtl/core/stq_pkg.sv */
package stq_pkg;

    localparam int STQ_DEPTH      = 16;
    localparam int STQ_ID_WIDTH   = 10;
    localparam int STQ_TIME_WIDTH = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_EXPIRED  = 3'd4;

endpackage

/* rtl/core/stq_ram.sv */
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/sorted_timer_queue.sv */
// Add, delete and adjust search linearly for the id; adjust then re-inserts it by time.
// Tick: removes the head while it is due, giving one expired id per removal.
// One item at a time: the input stalls until the item is done and its results are taken.
// Output stalls lengthen every operation that gives a result.
// Reset clears the entry count and the control state; RAM contents past the count are never used.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH      = STQ_DEPTH,
    parameter int ID_WIDTH   = STQ_ID_WIDTH,
    parameter int TIME_WIDTH = STQ_TIME_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [ID_WIDTH-1:0]   conn_id,
    input  logic [TIME_WIDTH-1:0] expire_time,
    input  logic [TIME_WIDTH-1:0] current_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [ID_WIDTH-1:0]   expired_id,
    output logic                  last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TIME_WIDTH + ID_WIDTH;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FRD    = 10'b0000000010,
        S_FCHK   = 10'b0000000100,
        S_RMRD   = 10'b0000001000,
        S_RMWR   = 10'b0000010000,
        S_INRD   = 10'b0000100000,
        S_INWR   = 10'b0001000000,
        S_TRD    = 10'b0010000000,
        S_TCHK   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [1:0]            op_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [TIME_WIDTH-1:0] t_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic          ov_reg, ov_next;
    logic [2:0]    ost_reg, ost_next;
    logic [ID_WIDTH-1:0] oid_reg, oid_next;
    logic          olast_reg, olast_next;
    // tick: number of entries removed so far in this tick
    logic [CW-1:0] tn_reg, tn_next;
    // hold the expired id until the next head shows whether it is the last
    logic [ID_WIDTH-1:0] pid_reg, pid_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [TIME_WIDTH-1:0] rd_t;
    logic [ID_WIDTH-1:0]   rd_id;
    logic [CW-1:0] rd_idx;
    logic          head_due;

    assign rd_t  = rd_data[EW-1:ID_WIDTH];
    assign rd_id = rd_data[ID_WIDTH-1:0];
    assign head_due = (count_reg != '0) && (rd_t <= now_reg);

    stq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign in_stall   = (state_reg != S_IDLE) || ov_reg;
    assign out_valid  = ov_reg;
    assign status     = ost_reg;
    assign expired_id = oid_reg;
    assign last       = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        ost_reg   <= ost_next;
        oid_reg   <= oid_next;
        olast_reg <= olast_next;
        tn_reg    <= tn_next;
        pid_reg   <= pid_next;
        if (state_reg == S_IDLE && in_valid && !ov_reg)
        begin
            op_reg  <= operation;
            id_reg  <= conn_id;
            t_reg   <= expire_time;
            now_reg <= current_time;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        ov_next    = ov_reg && out_stall;
        ost_next   = ost_reg;
        oid_next   = oid_reg;
        olast_next = olast_reg;
        tn_next    = tn_reg;
        pid_next   = pid_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = {t_reg, id_reg};
        rd_idx     = idx_reg;
        rd_addr    = rd_idx[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    tn_next    = '0;
                    if (operation == OP_TICK)
                    begin
                        state_next = (count_reg == '0) ? S_IDLE : S_TRD;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            // linear search for the id
            S_FRD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (idx_reg < count_reg && rd_id == id_reg)
                begin
                    found_next = 1'b1;
                end
                if (idx_reg < count_reg && rd_id != id_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_idx     = idx_reg + 1'b1;
                    rd_addr    = rd_idx[AW-1:0];
                    state_next = S_FCHK;
                end
                else
                begin
                    oid_next   = id_reg;
                    olast_next = 1'b1;
                    ost_next   = ST_OK;
                    if (op_reg == OP_ADD)
                    begin
                        if (idx_reg < count_reg)
                        begin
                            ost_next = ST_DUP;
                            state_next = S_OUT;
                        end
                        else if (count_reg == CW'(DEPTH))
                        begin
                            ost_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INRD;
                        end
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        ost_next   = ST_NOTFOUND;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RMRD;
                    end
                end
            end
            // shift entries after idx one down
            S_RMRD:
            begin
                if (idx_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    if (op_reg == OP_ADJUST)
                    begin
                        idx_next   = count_reg - 1'b1;
                        state_next = S_INRD;
                    end
                    else if (tn_reg != '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    rd_idx     = idx_reg + 1'b1;
                    rd_addr    = rd_idx[AW-1:0];
                    state_next = S_RMWR;
                end
            end
            S_RMWR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_reg + 1'b1;
                state_next = S_RMRD;
            end
            // walk from the tail, moving later entries up
            S_INRD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    rd_idx     = idx_reg - 1'b1;
                    rd_addr    = rd_idx[AW-1:0];
                    state_next = S_INWR;
                end
            end
            S_INWR:
            begin
                wr_en = 1'b1;
                if (rd_t > t_reg)
                begin
                    wr_data    = rd_data;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_INRD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            // tick: head read
            S_TRD:
            begin
                rd_idx     = '0;
                rd_addr    = rd_idx[AW-1:0];
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                // keep the head on the read port while waiting for the output
                rd_idx  = '0;
                rd_addr = rd_idx[AW-1:0];
                if (tn_reg == '0 || !ov_next)
                begin
                    if (tn_reg != '0)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = ST_EXPIRED;
                        oid_next   = pid_reg;
                        olast_next = !head_due;
                    end
                    if (head_due)
                    begin
                        pid_next = rd_id;
                        tn_next  = tn_reg + 1'b1;
                        idx_next = '0;
                        if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            state_next = S_RMRD;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // after a tick removal, go check the new head
        if (state_reg == S_RMRD && op_reg == OP_TICK && idx_reg + 1'b1 >= count_reg)
        begin
            state_next = S_TRD;
        end
    end

endmodule
